>>> design/ats_pkg.sv
`timescale 1ns / 1ps

package ats_pkg;

  localparam int unsigned ENTRIES       = 256;
  localparam int unsigned IDX_W         = $clog2(ENTRIES);
  localparam int unsigned CNT_W         = IDX_W + 1;
  localparam int unsigned WEIGHT_BITS   = 32;
  localparam int unsigned FRACTION_BITS = 32;
  localparam int unsigned PROB_W        = WEIGHT_BITS + CNT_W;
  localparam int unsigned FRAC_IN_W     = FRACTION_BITS + 1;
  localparam int unsigned DIVIDEND_W    = PROB_W + FRACTION_BITS;
  localparam int unsigned REM_W         = PROB_W + 1;
  localparam int unsigned STEP_W        = $clog2(DIVIDEND_W + 1);

  localparam logic [PROB_W-1:0] FIX_ONE = PROB_W'(1) << FRACTION_BITS;

  typedef enum logic [1:0] {
    FUNC_CLEAR  = 2'd0,
    FUNC_APPEND = 2'd1,
    FUNC_BUILD  = 2'd2,
    FUNC_DRAW   = 2'd3
  } func_e;

  typedef enum logic [1:0] {
    STAT_OK       = 2'd0,
    STAT_ZERO_SUM = 2'd1,
    STAT_FULL     = 2'd2,
    STAT_BAD_DRAW = 2'd3
  } status_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DRAW,
    ST_SC_RD,
    ST_SC_MUL,
    ST_SC_DIV,
    ST_PAIR_CHK,
    ST_PAIR_IDX,
    ST_PAIR_PJ,
    ST_PAIR_PK
  } state_e;

  typedef struct packed {
    logic                start;
    logic [PROB_W-1:0]   num;
    logic [PROB_W-1:0]   den;
  } div_req_t;

  typedef struct packed {
    logic                done;
    logic [PROB_W-1:0]   quot;
  } div_rsp_t;

endpackage

>>> design/ats_ram.sv
`timescale 1ns / 1ps

module ats_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

>>> design/ats_div.sv
`timescale 1ns / 1ps

module ats_div (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  ats_pkg::div_req_t req_i,
  output ats_pkg::div_rsp_t rsp_o
);

  logic [ats_pkg::DIVIDEND_W-1:0] dvd_q, dvd_d;
  logic [ats_pkg::REM_W-1:0]      rem_q, rem_d, rem_sh;
  logic [ats_pkg::PROB_W-1:0]     quot_q, quot_d, den_q, den_d;
  logic [ats_pkg::STEP_W-1:0]     step_q, step_d;
  logic                           busy_q, busy_d, done_q, done_d;

  always_comb begin
    dvd_d  = dvd_q;
    rem_d  = rem_q;
    quot_d = quot_q;
    den_d  = den_q;
    step_d = step_q;
    busy_d = busy_q;
    done_d = 1'b0;
    rem_sh = {rem_q[ats_pkg::REM_W-2:0], dvd_q[ats_pkg::DIVIDEND_W-1]};
    if (req_i.start) begin
      dvd_d  = {req_i.num, ats_pkg::FRACTION_BITS'(0)};
      rem_d  = '0;
      quot_d = '0;
      den_d  = req_i.den;
      step_d = ats_pkg::STEP_W'(ats_pkg::DIVIDEND_W);
      busy_d = 1'b1;
    end else if (busy_q) begin
      dvd_d = {dvd_q[ats_pkg::DIVIDEND_W-2:0], 1'b0};
      if (rem_sh >= {1'b0, den_q}) begin
        rem_d  = rem_sh - {1'b0, den_q};
        quot_d = {quot_q[ats_pkg::PROB_W-2:0], 1'b1};
      end else begin
        rem_d  = rem_sh;
        quot_d = {quot_q[ats_pkg::PROB_W-2:0], 1'b0};
      end
      step_d = step_q - 1'b1;
      if (step_q == ats_pkg::STEP_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q  <= dvd_d;
    rem_q  <= rem_d;
    quot_q <= quot_d;
    den_q  <= den_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = quot_q;

endmodule

>>> design/alias_table_sampler.sv
`timescale 1ns / 1ps

// Walker alias table over up to 256 outcomes, one request at a time with one
// response per request. Clear and append load their response in the cycle they
// are accepted; a valid draw first waits in ST_DRAW for the registered read of the
// probability and alias memories. A build scales every entry with a bit-serial
// divider in ST_SC_RD, ST_SC_MUL and ST_SC_DIV, then pairs short and long entries
// in ST_PAIR_CHK to ST_PAIR_PK; no request is taken until the build is finished.
module alias_table_sampler (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  func_i,
  input  logic [31:0] weight_i,
  input  logic [7:0]  column_i,
  input  logic [32:0] fraction_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  index_o,
  output logic [1:0]  status_o
);

  localparam int unsigned IW = ats_pkg::IDX_W;
  localparam int unsigned CW = ats_pkg::CNT_W;
  localparam int unsigned PW = ats_pkg::PROB_W;

  ats_pkg::state_e state_q, state_d;

  logic [CW-1:0] cnt_q, cnt_d, i_q, i_d, st_q, st_d, lt_q, lt_d;
  logic [PW-1:0] sum_q, sum_d, pj_q, pj_d;
  logic          built_q, built_d, fresh_q, fresh_d;
  logic [IW-1:0] j_q, j_d, k_q, k_d, col_q, col_d;
  logic [ats_pkg::FRAC_IN_W-1:0] u_q, u_d;
  logic          out_valid_q, out_load;
  logic [7:0]    index_q, index_d;
  logic [1:0]    status_q, status_d;

  logic          p_we;
  logic [IW-1:0] p_waddr, p_raddr;
  logic [PW-1:0] p_wdata, p_rdata;
  logic          a_we;
  logic [IW-1:0] a_waddr, a_wdata, a_raddr, a_rdata;
  logic          s_we, l_we;
  logic [IW-1:0] s_waddr, s_wdata, s_raddr, s_rdata;
  logic [IW-1:0] l_waddr, l_wdata, l_raddr, l_rdata;

  ats_pkg::div_req_t div_req;
  ats_pkg::div_rsp_t div_rsp;

  logic [CW-1:0] cnt_eff;
  logic [PW-1:0] p_new;
  logic          accept;

  ats_ram #(.Width(PW), .Depth(ats_pkg::ENTRIES)) u_prob (
    .clk_i, .we_i(p_we), .waddr_i(p_waddr), .wdata_i(p_wdata),
    .raddr_i(p_raddr), .rdata_o(p_rdata)
  );

  ats_ram #(.Width(IW), .Depth(ats_pkg::ENTRIES)) u_alias (
    .clk_i, .we_i(a_we), .waddr_i(a_waddr), .wdata_i(a_wdata),
    .raddr_i(a_raddr), .rdata_o(a_rdata)
  );

  ats_ram #(.Width(IW), .Depth(ats_pkg::ENTRIES)) u_short (
    .clk_i, .we_i(s_we), .waddr_i(s_waddr), .wdata_i(s_wdata),
    .raddr_i(s_raddr), .rdata_o(s_rdata)
  );

  ats_ram #(.Width(IW), .Depth(ats_pkg::ENTRIES)) u_long (
    .clk_i, .we_i(l_we), .waddr_i(l_waddr), .wdata_i(l_wdata),
    .raddr_i(l_raddr), .rdata_o(l_rdata)
  );

  ats_div u_div (
    .clk_i, .rst_ni, .req_i(div_req), .rsp_o(div_rsp)
  );

  assign in_ready_o = (state_q == ats_pkg::ST_IDLE) && (!out_valid_q || out_ready_i);
  assign accept     = in_valid_i && in_ready_o;
  assign cnt_eff    = built_q ? '0 : cnt_q;
  assign p_new      = p_rdata + pj_q - ats_pkg::FIX_ONE;

  always_comb begin
    state_d  = state_q;
    cnt_d    = cnt_q;
    sum_d    = sum_q;
    built_d  = built_q;
    fresh_d  = fresh_q;
    i_d      = i_q;
    st_d     = st_q;
    lt_d     = lt_q;
    j_d      = j_q;
    k_d      = k_q;
    pj_d     = pj_q;
    col_d    = col_q;
    u_d      = u_q;
    out_load = 1'b0;
    index_d  = '0;
    status_d = ats_pkg::STAT_OK;
    p_we     = 1'b0;
    p_waddr  = i_q[IW-1:0];
    p_wdata  = div_rsp.quot;
    p_raddr  = i_q[IW-1:0];
    a_we     = 1'b0;
    a_waddr  = i_q[IW-1:0];
    a_wdata  = i_q[IW-1:0];
    a_raddr  = col_q;
    s_we     = 1'b0;
    s_waddr  = st_q[IW-1:0];
    s_wdata  = i_q[IW-1:0];
    s_raddr  = IW'(st_q - 1'b1);
    l_we     = 1'b0;
    l_waddr  = lt_q[IW-1:0];
    l_wdata  = i_q[IW-1:0];
    l_raddr  = IW'(lt_q - 1'b1);
    div_req.start = 1'b0;
    div_req.num   = PW'(p_rdata[ats_pkg::WEIGHT_BITS-1:0] * cnt_q);
    div_req.den   = sum_q;

    unique case (state_q)
      ats_pkg::ST_IDLE: begin
        p_raddr = column_i;
        a_raddr = column_i;
        if (accept) begin
          unique case (ats_pkg::func_e'(func_i))
            ats_pkg::FUNC_CLEAR: begin
              cnt_d    = '0;
              sum_d    = '0;
              built_d  = 1'b0;
              fresh_d  = 1'b0;
              out_load = 1'b1;
            end
            ats_pkg::FUNC_APPEND: begin
              out_load = 1'b1;
              fresh_d  = 1'b0;
              built_d  = 1'b0;
              if (cnt_eff == CW'(ats_pkg::ENTRIES)) begin
                cnt_d    = cnt_eff;
                sum_d    = built_q ? '0 : sum_q;
                status_d = ats_pkg::STAT_FULL;
              end else begin
                p_we    = 1'b1;
                p_waddr = cnt_eff[IW-1:0];
                p_wdata = PW'(weight_i[ats_pkg::WEIGHT_BITS-1:0]);
                cnt_d   = cnt_eff + 1'b1;
                sum_d   = (built_q ? '0 : sum_q) + PW'(weight_i[ats_pkg::WEIGHT_BITS-1:0]);
              end
            end
            ats_pkg::FUNC_BUILD: begin
              if (built_q) begin
                out_load = 1'b1;
              end else if (cnt_q == '0 || sum_q == '0) begin
                out_load = 1'b1;
                status_d = ats_pkg::STAT_ZERO_SUM;
              end else begin
                i_d     = '0;
                st_d    = '0;
                lt_d    = '0;
                state_d = ats_pkg::ST_SC_RD;
              end
            end
            ats_pkg::FUNC_DRAW: begin
              if (!built_q || CW'(column_i) >= cnt_q) begin
                out_load = 1'b1;
                status_d = ats_pkg::STAT_BAD_DRAW;
              end else begin
                col_d   = column_i;
                u_d     = fraction_i;
                state_d = ats_pkg::ST_DRAW;
              end
            end
            default: ;
          endcase
        end
      end
      ats_pkg::ST_DRAW: begin
        out_load = 1'b1;
        if (fresh_q || PW'(u_q) <= p_rdata) begin
          index_d = fresh_q ? '0 : col_q;
        end else begin
          index_d = a_rdata;
        end
        state_d = ats_pkg::ST_IDLE;
      end
      ats_pkg::ST_SC_RD: begin
        state_d = ats_pkg::ST_SC_MUL;
      end
      ats_pkg::ST_SC_MUL: begin
        div_req.start = 1'b1;
        state_d       = ats_pkg::ST_SC_DIV;
      end
      ats_pkg::ST_SC_DIV: begin
        if (div_rsp.done) begin
          p_we = 1'b1;
          a_we = 1'b1;
          if (div_rsp.quot < ats_pkg::FIX_ONE) begin
            s_we = 1'b1;
            st_d = st_q + 1'b1;
          end
          if (div_rsp.quot > ats_pkg::FIX_ONE) begin
            l_we = 1'b1;
            lt_d = lt_q + 1'b1;
          end
          i_d = i_q + 1'b1;
          if (i_q + 1'b1 == cnt_q) begin
            state_d = ats_pkg::ST_PAIR_CHK;
          end else begin
            state_d = ats_pkg::ST_SC_RD;
          end
        end
      end
      ats_pkg::ST_PAIR_CHK: begin
        if (st_q != '0 && lt_q != '0) begin
          st_d    = st_q - 1'b1;
          state_d = ats_pkg::ST_PAIR_IDX;
        end else begin
          built_d  = 1'b1;
          out_load = 1'b1;
          state_d  = ats_pkg::ST_IDLE;
        end
      end
      ats_pkg::ST_PAIR_IDX: begin
        j_d     = s_rdata;
        k_d     = l_rdata;
        p_raddr = s_rdata;
        state_d = ats_pkg::ST_PAIR_PJ;
      end
      ats_pkg::ST_PAIR_PJ: begin
        pj_d    = p_rdata;
        p_raddr = k_q;
        state_d = ats_pkg::ST_PAIR_PK;
      end
      ats_pkg::ST_PAIR_PK: begin
        p_we    = 1'b1;
        p_waddr = k_q;
        p_wdata = p_new;
        a_we    = 1'b1;
        a_waddr = j_q;
        a_wdata = k_q;
        if (p_new < ats_pkg::FIX_ONE) begin
          s_we    = 1'b1;
          s_wdata = k_q;
          st_d    = st_q + 1'b1;
          lt_d    = lt_q - 1'b1;
        end
        state_d = ats_pkg::ST_PAIR_CHK;
      end
      default: state_d = ats_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ats_pkg::ST_IDLE;
      cnt_q       <= CW'(1);
      sum_q       <= PW'(1);
      built_q     <= 1'b1;
      fresh_q     <= 1'b1;
      i_q         <= '0;
      st_q        <= '0;
      lt_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      sum_q   <= sum_d;
      built_q <= built_d;
      fresh_q <= fresh_d;
      i_q     <= i_d;
      st_q    <= st_d;
      lt_q    <= lt_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    j_q   <= j_d;
    k_q   <= k_d;
    pj_q  <= pj_d;
    col_q <= col_d;
    u_q   <= u_d;
    if (out_load) begin
      index_q  <= index_d;
      status_q <= status_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign index_o     = index_q;
  assign status_o    = status_q;

endmodule
